### design/dns_name_label_encoder_core_macros.svh
// ---------------------------------------------------------------------------
// dns name label encoder assertion macros
// shared concurrent check forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef DNS_NAME_LABEL_ENCODER_CORE_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_CORE_MACROS_SVH

// same-cycle implication
`define DNSLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dnsle check failed");

// next-cycle implication
`define DNSLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dnsle check failed");

`endif

### design/dnsle_pkg.sv
// ---------------------------------------------------------------------------
// dnsle_pkg
// types and constants of the dns name label encoder
// ---------------------------------------------------------------------------
package dnsle_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word16;

    // label store depth, 1 to 63
    localparam int MAX_LABEL = 32;
    localparam int CNT_W     = 6;
    localparam int IDX_W     = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

    localparam t_byte CH_DOT = 8'd46;
    localparam t_byte CH_END = 8'd0;

endpackage

### design/dnsle_if.sv
// ---------------------------------------------------------------------------
// dnsle channel interfaces
// character request channel and encoded byte channel
// ---------------------------------------------------------------------------
interface dnsle_in_if import dnsle_pkg::*; ();
    logic    valid;
    logic    ready;
    t_byte   ch;
    t_word16 query_type;
    t_word16 query_class;

    modport source (output valid, output ch, output query_type, output query_class,
                    input ready);
    modport sink   (input valid, input ch, input query_type, input query_class,
                    output ready);
endinterface

interface dnsle_out_if import dnsle_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  run_last;
    logic  label_overflow;

    modport source (output valid, output out_byte, output run_last, output label_overflow,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input label_overflow,
                    output ready);
endinterface

### design/dnsle_ram.sv
// ---------------------------------------------------------------------------
// dnsle_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module dnsle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/dns_name_label_encoder_core.sv
// ---------------------------------------------------------------------------
// dns_name_label_encoder_core
// dotted name to dns question wire format encoder
// ---------------------------------------------------------------------------
// usage:
//   i_in carries one name character per request; a dot closes a label and a
//   zero character ends the name and brings query_type and query_class.
//   o_out carries the encoded question one byte per request: length byte and
//   label characters, then the root byte, type and class high byte first,
//   run_last on the final byte, label_overflow on a clipped length byte.
// throughput:
//   an ordinary character is one write into the label ram. a dot or the
//   terminator sends length byte and label characters, at the terminator then
//   root, type and class bytes, one byte per cycle paced by the single read
//   port while the receiver does not stall; an empty label has no length byte.
// burst start:
//   the dot or terminator moves control to the len state (the tail state for an
//   empty last label), which loads the first byte into the free output register.
// stall:
//   a stalled receiver holds the output register and the burst waits;
//   characters are accepted only in idle, also while a label's last byte waits.
// reset:
//   synchronous, active low; clears count, overflow flag and control state.
//   the label ram needs no clearing, only written entries are read.
// ---------------------------------------------------------------------------
`include "dns_name_label_encoder_core_macros.svh"

module dns_name_label_encoder_core import dnsle_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnsle_in_if.sink      i_in,
    dnsle_out_if.source   o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_DATA,
        S_TAIL
    } t_state;

    typedef enum logic [2:0] {
        T_ROOT,
        T_TYPE_HI,
        T_TYPE_LO,
        T_CLASS_HI,
        T_CLASS_LO
    } t_tail_step;

    t_state     r_state, n_state;
    t_tail_step r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic       r_ovf, n_ovf;
    logic       r_is_end, n_is_end;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_word16    r_qt, n_qt;
    t_word16    r_qc, n_qc;

    logic       r_out_valid, n_out_valid;
    t_byte      r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;
    logic       r_out_ovf, n_out_ovf;

    logic       w_in_acc;
    logic       w_free;
    logic       w_plain;
    logic       w_wr_en;
    logic       w_idx_last;
    t_byte      w_rd_data;

    // writes happen only in idle and read data is used only during a burst, so
    // the single ram never sees a used read meet a write of the same entry
    dnsle_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LABEL)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (i_in.ch),
        .i_rd_addr (n_idx),
        .o_rd_data (w_rd_data)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && (r_state == S_IDLE);
    assign w_free     = !r_out_valid || o_out.ready;
    assign w_plain    = (i_in.ch != CH_DOT) && (i_in.ch != CH_END);
    assign w_wr_en    = w_in_acc && w_plain && (r_count < CNT_W'(MAX_LABEL));
    assign w_idx_last = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    always_comb begin
        n_state     = r_state;
        n_tail      = r_tail;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_is_end    = r_is_end;
        n_idx       = r_idx;
        n_qt        = r_qt;
        n_qc        = r_qc;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (w_in_acc) begin
                    if (i_in.ch == CH_DOT) begin
                        n_is_end = 1'b0;
                        // empty inner label gives no byte
                        if ((r_count != '0) || r_ovf) begin
                            n_state = S_LEN;
                        end
                    end else if (i_in.ch == CH_END) begin
                        n_is_end = 1'b1;
                        n_qt     = i_in.query_type;
                        n_qc     = i_in.query_class;
                        n_tail   = T_ROOT;
                        if ((r_count != '0) || r_ovf) begin
                            n_state = S_LEN;
                        end else begin
                            n_state = S_TAIL;
                        end
                    end else if (r_count < CNT_W'(MAX_LABEL)) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_LEN: begin
                n_idx = '0;
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = 8'(r_count);
                    n_out_last  = 1'b0;
                    n_out_ovf   = r_ovf;
                    if (r_count != '0) begin
                        n_state = S_DATA;
                    end else begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_tail  = T_ROOT;
                        n_state = r_is_end ? S_TAIL : S_IDLE;
                    end
                end
            end
            S_DATA: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_byte  = w_rd_data;
                    n_out_last  = 1'b0;
                    n_out_ovf   = 1'b0;
                    if (w_idx_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_idx   = '0;
                        n_tail  = T_ROOT;
                        n_state = r_is_end ? S_TAIL : S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            S_TAIL: begin
                if (w_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b0;
                    n_out_ovf   = 1'b0;
                    unique case (r_tail)
                        T_ROOT: begin
                            n_out_byte = 8'd0;
                            n_tail     = T_TYPE_HI;
                        end
                        T_TYPE_HI: begin
                            n_out_byte = r_qt[15:8];
                            n_tail     = T_TYPE_LO;
                        end
                        T_TYPE_LO: begin
                            n_out_byte = r_qt[7:0];
                            n_tail     = T_CLASS_HI;
                        end
                        T_CLASS_HI: begin
                            n_out_byte = r_qc[15:8];
                            n_tail     = T_CLASS_LO;
                        end
                        T_CLASS_LO: begin
                            n_out_byte = r_qc[7:0];
                            n_out_last = 1'b1;
                            n_tail     = T_ROOT;
                            n_state    = S_IDLE;
                        end
                        default: begin
                            n_out_valid = 1'b0;
                            n_tail      = T_ROOT;
                            n_state     = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tail      <= T_ROOT;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_is_end    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_is_end    <= n_is_end;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
        r_qt       <= n_qt;
        r_qc       <= n_qc;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.run_last       = r_out_last;
    assign o_out.label_overflow = r_out_ovf;

    `DNSLE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= CNT_W'(MAX_LABEL))
    `DNSLE_ASSERT_NOW(a_data_in_label, i_clk, i_rst_n, r_state == S_DATA,
        (r_count != '0) && (CNT_W'(r_idx) < r_count))
    `DNSLE_ASSERT_NEXT(a_char_stored, i_clk, i_rst_n, w_wr_en,
        (r_count == $past(r_count) + CNT_W'(1)) && (r_state == S_IDLE))

endmodule
